### rtl/core/bfra_pkg.sv
`default_nettype none
package bfra_pkg;

  localparam int unsigned ID_W     = 12;
  localparam int unsigned HEIGHT_W = 9;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND
  } state_t;

endpackage
`default_nettype wire

### rtl/core/bounded_fifo_running_average_top.sv
`default_nettype none
// Bounded queue of (id, height) entries with a running mean of the held heights.
// An insert drops the oldest entry when CAPACITY entries are held, appends the new
// one and reports the mean height rounded to nearest, ties to even. A remove
// reports the oldest id, or raises out_error on an empty queue. start is taken
// while busy is low. A remove's result is registered and appears in the cycle
// after acceptance, and busy stays low. An insert holds busy high through ST_DIV,
// a restoring divider that forms one bit per cycle of a SUM_W-bit quotient, where
// SUM_W = 9 + clog2(CAPACITY + 1) and is 12 at the default, then through a single
// rounding step in ST_ROUND; the result appears in the cycle after ST_ROUND.
// out_valid marks each result for exactly one cycle. The receiver cannot stall
// the block, so it must take the result in that cycle.
module bounded_fifo_running_average_top #(
  parameter int unsigned CAPACITY = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_req_type,
  input  wire logic [bfra_pkg::ID_W-1:0]      in_player_id,
  input  wire logic [bfra_pkg::HEIGHT_W-1:0]  in_height,
  output logic                                out_valid,
  output logic [bfra_pkg::HEIGHT_W-1:0]       out_avg_height,
  output logic [bfra_pkg::ID_W-1:0]           out_removed_id,
  output logic                                out_error
);

  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned PTR_W  = CNT_W + 1;
  localparam int unsigned SUM_W  = bfra_pkg::HEIGHT_W + CNT_W;
  localparam int unsigned REM_W  = CNT_W + 1;
  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  bfra_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bfra_pkg::HEIGHT_W-1:0] avg_r, avg_nxt;
  logic [bfra_pkg::ID_W-1:0]     rid_r, rid_nxt;
  logic                         err_r, err_nxt;

  logic [bfra_pkg::HEIGHT_W-1:0] hmem_r [CAPACITY];
  logic [bfra_pkg::ID_W-1:0]     imem_r [CAPACITY];

  logic                          wr_en;
  logic [IDX_W-1:0]              wr_idx;
  logic [bfra_pkg::HEIGHT_W-1:0] head_hgt;
  logic [bfra_pkg::ID_W-1:0]     head_id;
  logic [IDX_W-1:0]              head_inc;
  logic [PTR_W-1:0]              tail_raw;
  logic [IDX_W-1:0]              tail_idx;
  logic                          full;
  logic                          accept;
  logic [REM_W-1:0]              rem_shift;
  logic                          rem_ge;
  logic [REM_W:0]                rem_dbl;
  logic [REM_W:0]                cnt_ext;
  logic [SUM_W-1:0]              q_round;

  assign accept   = start && !busy;
  assign head_hgt = hmem_r[head_r];
  assign head_id  = imem_r[head_r];
  assign full     = (cnt_r == CAP_C);
  assign head_inc = (PTR_W'(head_r) + PTR_W'(1) == CAP_P) ? '0 : IDX_W'(head_r + IDX_W'(1));
  assign tail_raw = PTR_W'(head_r) + PTR_W'(cnt_r);
  assign tail_idx = (tail_raw >= CAP_P) ? IDX_W'(tail_raw - CAP_P) : IDX_W'(tail_raw);

  assign rem_shift = {rem_r[REM_W-2:0], quo_r[SUM_W-1]};
  assign rem_ge    = (rem_shift >= REM_W'(cnt_r));
  assign rem_dbl   = {rem_r, 1'b0};
  assign cnt_ext   = (REM_W+1)'(cnt_r);

  always_comb begin
    if (rem_dbl > cnt_ext) begin
      q_round = quo_r + SUM_W'(1);
    end else if (rem_dbl == cnt_ext) begin
      q_round = quo_r + SUM_W'(quo_r[0]);
    end else begin
      q_round = quo_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    avg_nxt       = avg_r;
    rid_nxt       = rid_r;
    err_nxt       = err_r;
    wr_en         = 1'b0;
    wr_idx        = tail_idx;
    busy          = (state_r != bfra_pkg::ST_IDLE);
    unique case (state_r)
      bfra_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req_type == bfra_pkg::REQ_INSERT) begin
            wr_en = 1'b1;
            if (full) begin
              wr_idx   = head_r;
              head_nxt = head_inc;
              sum_nxt  = sum_r - SUM_W'(head_hgt) + SUM_W'(in_height);
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
              sum_nxt = sum_r + SUM_W'(in_height);
            end
            quo_nxt   = sum_nxt;
            rem_nxt   = '0;
            step_nxt  = STEP_W'(SUM_W - 1);
            state_nxt = bfra_pkg::ST_DIV;
          end else begin
            out_valid_nxt = 1'b1;
            avg_nxt       = '0;
            if (cnt_r == '0) begin
              err_nxt = 1'b1;
              rid_nxt = '0;
            end else begin
              err_nxt  = 1'b0;
              rid_nxt  = head_id;
              head_nxt = head_inc;
              cnt_nxt  = cnt_r - CNT_W'(1);
              sum_nxt  = sum_r - SUM_W'(head_hgt);
            end
          end
        end
      end
      bfra_pkg::ST_DIV: begin
        rem_nxt  = rem_ge ? REM_W'(rem_shift - REM_W'(cnt_r)) : rem_shift;
        quo_nxt  = {quo_r[SUM_W-2:0], rem_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = bfra_pkg::ST_ROUND;
        end
      end
      bfra_pkg::ST_ROUND: begin
        out_valid_nxt = 1'b1;
        avg_nxt       = q_round[bfra_pkg::HEIGHT_W-1:0];
        rid_nxt       = '0;
        err_nxt       = 1'b0;
        state_nxt     = bfra_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bfra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfra_pkg::ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    avg_r  <= avg_nxt;
    rid_r  <= rid_nxt;
    err_r  <= err_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hmem_r[wr_idx] <= in_height;
      imem_r[wr_idx] <= in_player_id;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_avg_height = avg_r;
  assign out_removed_id = rid_r;
  assign out_error      = err_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("entry count above capacity");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> sum_r == '0)
    else $error("height sum nonzero on empty queue");

  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> cnt_r == '0)
    else $error("error reported with entries held");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted item neither started nor answered");

endmodule
`default_nettype wire
